// ===== src/sahs_pkg.sv =====
// Shared types and constants for the stepper axis homing sequencer.
package sahs_pkg;

    // Item operation codes
    localparam logic [2:0] OP_STEP      = 3'd0;
    localparam logic [2:0] OP_TICK      = 3'd1;
    localparam logic [2:0] OP_RIGHT_LIM = 3'd2;
    localparam logic [2:0] OP_LEFT_LIM  = 3'd3;
    localparam logic [2:0] OP_STOP      = 3'd4;
    localparam logic [2:0] OP_LOAD      = 3'd5;
    localparam logic [2:0] OP_SET_MODE  = 3'd6;

    // Sequencer modes
    localparam logic [2:0] MODE_IDLE      = 3'd0;
    localparam logic [2:0] MODE_SEEK_LEFT = 3'd1;
    localparam logic [2:0] MODE_CENTERING = 3'd2;
    localparam logic [2:0] MODE_CENTERED  = 3'd3;
    localparam logic [2:0] MODE_RETURN    = 3'd4;
    localparam logic [2:0] MODE_PROFILE   = 3'd5;
    localparam logic [2:0] MODE_SPARE     = 3'd6;

    // Configuration register indexes
    localparam logic CFG_HOME_POSITION = 1'b0;
    localparam logic CFG_PROFILE_LAST  = 1'b1;

    localparam logic [9:0] PROFILE_LAST_RESET = 10'd999;

    typedef struct packed {
        logic [2:0]         op;
        logic               limit_active;
        logic [9:0]         table_index;
        logic signed [16:0] table_period;
        logic [2:0]         new_mode;
        logic               run_request;
    } t_item;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] position;
        logic               direction;
        logic               step_run;
        logic [15:0]        step_period;
        logic [14:0]        step_compare;
        logic               period_load;
        logic               drive_indicator;
        logic               home_done;
        logic signed [31:0] center_position;
    } t_result;

endpackage

// ===== src/sahs_item_if.sv =====
// Input item channel: valid/ready handshake with event payload.
interface sahs_item_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic               limit_active;
    logic [9:0]         table_index;
    logic signed [16:0] table_period;
    logic [2:0]         new_mode;
    logic               run_request;

    modport source (
        output valid, op, limit_active, table_index, table_period, new_mode, run_request,
        input  ready
    );
    modport sink (
        input  valid, op, limit_active, table_index, table_period, new_mode, run_request,
        output ready
    );
endinterface

// ===== src/sahs_result_if.sv =====
// Result channel: valid/ready handshake with axis status payload.
interface sahs_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic signed [31:0] position;
    logic               direction;
    logic               step_run;
    logic [15:0]        step_period;
    logic [14:0]        step_compare;
    logic               period_load;
    logic               drive_indicator;
    logic               home_done;
    logic signed [31:0] center_position;

    modport source (
        output valid, mode, position, direction, step_run, step_period, step_compare,
               period_load, drive_indicator, home_done, center_position,
        input  ready
    );
    modport sink (
        input  valid, mode, position, direction, step_run, step_period, step_compare,
               period_load, drive_indicator, home_done, center_position,
        output ready
    );
endinterface

// ===== src/sahs_prof_mem.sv =====
// Profile period table: one write port, one registered read port.
module sahs_prof_mem #(
    parameter int PROFILE_DEPTH = 1024,
    parameter int AW            = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [16:0]       i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [16:0]       o_rdata
);

    logic [16:0] mem [PROFILE_DEPTH];
    logic [16:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sahs_core.sv =====
// Axis state registers, configuration and per-item update logic.
module sahs_core #(
    parameter int PROFILE_DEPTH  = 1024,
    parameter int POSITION_WIDTH = 32,
    parameter int AW             = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [31:0]      i_cfg_data,
    input  logic             i_exec,
    input  sahs_pkg::t_item  i_item,
    input  logic [16:0]      i_rd_data,
    output logic [AW-1:0]    o_rd_addr,
    output sahs_pkg::t_result o_result
);
    import sahs_pkg::*;

    localparam int PW = POSITION_WIDTH;
    localparam int LAST_IDX = PROFILE_DEPTH - 1;

    logic [2:0]         r_mode,    n_mode;
    logic [PW-1:0]      r_pos,     n_pos;
    logic               r_dir,     n_dir;
    logic               r_run,     n_run;
    logic [PW-1:0]      r_centre,  n_centre;
    logic [AW-1:0]      r_pidx,    n_pidx;
    logic               r_ind,     n_ind;
    logic [15:0]        r_period,  n_period;
    logic [14:0]        r_compare, n_compare;
    logic signed [31:0] r_home;
    logic [9:0]         r_last;

    logic               loaded;
    logic               done;
    logic [PW-1:0]      pos_step;
    logic [PW-1:0]      pos_rnd;
    logic [PW-1:0]      half_pos;
    logic signed [63:0] home_ext;
    logic [PW-1:0]      home_pw;
    logic [AW-1:0]      cur_idx;
    logic [16:0]        mag;
    logic signed [63:0] pos_ext;
    logic signed [63:0] centre_ext;

    // index above profile_last restarts at entry zero
    function automatic logic [AW-1:0] norm_idx(input logic [AW-1:0] idx,
                                               input logic [9:0] last);
        return (32'(idx) > 32'(last)) ? {AW{1'b0}} : idx;
    endfunction

    assign pos_step = r_dir ? (r_pos + PW'(1)) : (r_pos - PW'(1));
    // half truncated toward zero: bias negatives by one before the shift
    assign pos_rnd  = r_pos + PW'(r_pos[PW-1]);
    assign half_pos = PW'($signed(pos_rnd) >>> 1);
    assign home_ext = 64'(r_home);
    assign home_pw  = home_ext[PW-1:0];
    assign cur_idx  = norm_idx(r_pidx, r_last);
    assign mag      = i_rd_data[16] ? (17'd0 - i_rd_data) : i_rd_data;

    always_comb begin
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_dir     = r_dir;
        n_run     = r_run;
        n_centre  = r_centre;
        n_pidx    = r_pidx;
        n_ind     = r_ind;
        n_period  = r_period;
        n_compare = r_compare;
        loaded    = 1'b0;
        done      = 1'b0;
        if (i_exec) begin
            case (i_item.op)
                OP_STEP: begin
                    n_pos = pos_step;
                    if (r_mode == MODE_CENTERING && pos_step == r_centre) begin
                        n_run  = 1'b0;
                        n_mode = MODE_CENTERED;
                        done   = 1'b1;
                    end
                    if (r_mode == MODE_RETURN && pos_step == home_pw) begin
                        n_pidx = {AW{1'b0}};
                        n_mode = MODE_PROFILE;
                        done   = 1'b1;
                    end
                end
                OP_TICK: begin
                    if (r_mode == MODE_PROFILE) begin
                        n_dir     = ~i_rd_data[16];
                        n_period  = mag[16] ? 16'hFFFF : mag[15:0];
                        n_compare = mag[16] ? 15'h7FFF : mag[15:1];
                        loaded    = 1'b1;
                        n_pidx    = (cur_idx == AW'(LAST_IDX)) ? {AW{1'b0}}
                                                               : cur_idx + AW'(1);
                    end
                end
                OP_RIGHT_LIM: begin
                    if (i_item.limit_active) begin
                        if (r_mode == MODE_IDLE || r_mode == MODE_SEEK_LEFT) begin
                            n_pos  = {PW{1'b0}};
                            n_dir  = 1'b0;
                            n_mode = MODE_SEEK_LEFT;
                        end else begin
                            n_mode = MODE_IDLE;
                            n_ind  = 1'b0;
                        end
                    end
                end
                OP_LEFT_LIM: begin
                    if (i_item.limit_active) begin
                        if (r_mode == MODE_SEEK_LEFT) begin
                            n_centre = half_pos;
                            n_dir    = 1'b1;
                            n_mode   = MODE_CENTERING;
                        end else if (r_mode == MODE_CENTERED || r_mode == MODE_RETURN ||
                                     r_mode == MODE_PROFILE || r_mode == MODE_SPARE) begin
                            n_mode = MODE_IDLE;
                            n_ind  = 1'b0;
                        end
                    end
                end
                OP_STOP: begin
                    n_ind  = ~r_ind;
                    n_mode = MODE_IDLE;
                end
                OP_SET_MODE: begin
                    n_mode = i_item.new_mode;
                    n_run  = i_item.run_request;
                end
                default: begin
                end
            endcase
        end
    end

    // table read for the item entering now uses the index this cycle leaves
    assign o_rd_addr = norm_idx(n_pidx, r_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_pos     <= '0;
            r_dir     <= 1'b0;
            r_run     <= 1'b0;
            r_centre  <= '0;
            r_pidx    <= '0;
            r_ind     <= 1'b0;
            r_period  <= '0;
            r_compare <= '0;
            r_home    <= '0;
            r_last    <= PROFILE_LAST_RESET;
        end else begin
            r_mode    <= n_mode;
            r_pos     <= n_pos;
            r_dir     <= n_dir;
            r_run     <= n_run;
            r_centre  <= n_centre;
            r_pidx    <= n_pidx;
            r_ind     <= n_ind;
            r_period  <= n_period;
            r_compare <= n_compare;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_HOME_POSITION: r_home <= i_cfg_data;
                    CFG_PROFILE_LAST:  r_last <= i_cfg_data[9:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign pos_ext    = 64'($signed(n_pos));
    assign centre_ext = 64'($signed(n_centre));

    always_comb begin
        o_result.mode            = n_mode;
        o_result.position        = pos_ext[31:0];
        o_result.direction       = n_dir;
        o_result.step_run        = n_run;
        o_result.step_period     = n_period;
        o_result.step_compare    = n_compare;
        o_result.period_load     = loaded;
        o_result.drive_indicator = n_ind;
        o_result.home_done       = done;
        o_result.center_position = centre_ext[31:0];
    end

endmodule

// ===== src/stepper_axis_homing_sequencer.sv =====
// Stepper axis homing sequencer top level: handshake pipeline, table and state.
//
// Takes one event per transfer (step pulse, profile tick, limit hits, stop,
// profile load, mode set) and returns exactly one status transfer per event.
// Throughput is one event per clock when the result side keeps up; an event
// accepted into the execute stage executes there once the output register can
// take its result, which it then holds until the result side takes it. The
// profile table is a synchronous single-read memory: the read for an event is
// issued at its accept edge, with the table index forwarded from the event
// executing in that same cycle, so back-to-back profile ticks need no bubble.
// Profile loads write the table at their accept edge, so a later tick always
// sees them. The output register lets a new event enter while a finished
// result waits; ready drops only when both the execute stage and the output
// register are full and the result side stalls. Table entries are not cleared
// by reset; no clearing pass runs, and the block is ready right after reset.
// Configuration (home_position at index 0, profile_last at index 1) must be
// written through the plain write port while the block is idle (not enforced).
module stepper_axis_homing_sequencer #(
    parameter int PROFILE_DEPTH  = 1024,
    parameter int POSITION_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    sahs_item_if.sink     i_item,
    sahs_result_if.source o_result
);
    import sahs_pkg::*;

    localparam int AW = (PROFILE_DEPTH > 1) ? $clog2(PROFILE_DEPTH) : 1;

    // execute stage holds the accepted item while its table read completes
    logic    r_s1_valid;
    t_item   r_s1_item;
    logic    r_out_valid;
    t_result r_out;

    t_item       in_item;
    t_result     exec_result;
    logic        in_xfer;
    logic        s1_adv;
    logic        tbl_we;
    logic [AW-1:0] rd_addr;
    logic [16:0] rd_data;

    assign in_item.op           = i_item.op;
    assign in_item.limit_active = i_item.limit_active;
    assign in_item.table_index  = i_item.table_index;
    assign in_item.table_period = i_item.table_period;
    assign in_item.new_mode     = i_item.new_mode;
    assign in_item.run_request  = i_item.run_request;

    assign s1_adv       = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_s1_valid || s1_adv;
    assign in_xfer      = i_item.valid && i_item.ready;

    // loads beyond the table depth are dropped
    assign tbl_we = in_xfer && (in_item.op == OP_LOAD) &&
                    (32'(in_item.table_index) < 32'(PROFILE_DEPTH));

    sahs_prof_mem #(
        .PROFILE_DEPTH (PROFILE_DEPTH),
        .AW            (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (AW'(in_item.table_index)),
        .i_wdata (in_item.table_period),
        .i_re    (in_xfer),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    sahs_core #(
        .PROFILE_DEPTH  (PROFILE_DEPTH),
        .POSITION_WIDTH (POSITION_WIDTH),
        .AW             (AW)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_exec     (s1_adv),
        .i_item     (r_s1_item),
        .i_rd_data  (rd_data),
        .o_rd_addr  (rd_addr),
        .o_result   (exec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_xfer) begin
            r_s1_item <= in_item;
        end
        if (s1_adv) begin
            r_out <= exec_result;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.mode            = r_out.mode;
    assign o_result.position        = r_out.position;
    assign o_result.direction       = r_out.direction;
    assign o_result.step_run        = r_out.step_run;
    assign o_result.step_period     = r_out.step_period;
    assign o_result.step_compare    = r_out.step_compare;
    assign o_result.period_load     = r_out.period_load;
    assign o_result.drive_indicator = r_out.drive_indicator;
    assign o_result.home_done       = r_out.home_done;
    assign o_result.center_position = r_out.center_position;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the stepper axis homing sequencer: random event stream, scoreboard.
module tb;
    import sahs_pkg::*;

    // Field values the package leaves unnamed
    localparam logic [2:0] OP_UNUSED   = 3'd7;
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    localparam int LONG_HOLD   = 250;   // receiver hold-off, long enough to back up the input
    localparam int STALL_LIMIT = 4000;  // cycles without any transfer before giving up

    typedef struct {
        t_item   ev;
        t_result status;
    } t_pending;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        cfg_we   = 1'b0;
    logic        cfg_idx  = 1'b0;
    logic [31:0] cfg_data = '0;

    sahs_item_if   item_ch ();
    sahs_result_if res_ch ();

    stepper_axis_homing_sequencer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_ch),
        .o_result   (res_ch)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Axis predictor: shadow of the sequencer state and its two registers
    // ------------------------------------------------------------------
    logic [31:0] home_cfg  = '0;
    logic [9:0]  plast_cfg = PROFILE_LAST_RESET;

    logic [2:0]  mode_q  = MODE_IDLE;
    logic [31:0] pos_q   = '0;
    logic        dir_q   = 1'b0;
    logic        run_q   = 1'b0;
    logic [31:0] ctr_q   = '0;
    logic [9:0]  pidx_q  = '0;
    logic        ind_q   = 1'b0;
    logic [15:0] per_q   = '0;
    logic [14:0] cmp_q   = '0;
    logic [16:0] table_q [1024];
    bit          written_q [1024];

    function automatic t_result axis_step(input t_item ev);
        t_result r;
        logic [16:0] e;
        logic [16:0] mag;
        r = '0;
        case (ev.op)
            OP_STEP: begin
                pos_q = dir_q ? pos_q + 32'd1 : pos_q - 32'd1;
                // centring ends on the centre and clears run; return ends on home and starts playback
                if (mode_q == MODE_CENTERING && pos_q == ctr_q) begin
                    run_q       = 1'b0;
                    mode_q      = MODE_CENTERED;
                    r.home_done = 1'b1;
                end
                if (mode_q == MODE_RETURN && pos_q == home_cfg) begin
                    pidx_q      = '0;
                    mode_q      = MODE_PROFILE;
                    r.home_done = 1'b1;
                end
            end
            OP_TICK: begin
                if (mode_q == MODE_PROFILE) begin
                    if (pidx_q > plast_cfg)
                        pidx_q = '0;
                    e     = table_q[pidx_q];
                    mag   = e[16] ? 17'd0 - e : e;
                    dir_q = ~e[16];                 // zero counts as up
                    // only the most negative entry has magnitude 65536
                    per_q = mag[16] ? 16'hFFFF : mag[15:0];
                    cmp_q = mag[16] ? 15'h7FFF : mag[15:1];
                    r.period_load = 1'b1;
                    pidx_q = pidx_q + 10'd1;        // wraps at the table depth
                end
            end
            OP_RIGHT_LIM: begin
                if (ev.limit_active) begin
                    if (mode_q == MODE_IDLE || mode_q == MODE_SEEK_LEFT) begin
                        pos_q  = '0;
                        dir_q  = 1'b0;
                        mode_q = MODE_SEEK_LEFT;
                    end else begin
                        mode_q = MODE_IDLE;
                        ind_q  = 1'b0;
                    end
                end
            end
            OP_LEFT_LIM: begin
                if (ev.limit_active) begin
                    if (mode_q == MODE_SEEK_LEFT) begin
                        ctr_q  = $signed(pos_q) / 32'sd2;   // truncates toward zero
                        dir_q  = 1'b1;
                        mode_q = MODE_CENTERING;
                    end else if (mode_q >= MODE_CENTERED && mode_q <= MODE_SPARE) begin
                        mode_q = MODE_IDLE;
                        ind_q  = 1'b0;
                    end
                end
            end
            OP_STOP: begin
                ind_q  = ~ind_q;
                mode_q = MODE_IDLE;
            end
            OP_LOAD: begin
                table_q[ev.table_index]   = ev.table_period;
                written_q[ev.table_index] = 1'b1;
            end
            OP_SET_MODE: begin
                mode_q = ev.new_mode;
                run_q  = ev.run_request;
            end
            default: ;
        endcase
        r.mode            = mode_q;
        r.position        = pos_q;
        r.direction       = dir_q;
        r.step_run        = run_q;
        r.step_period     = per_q;
        r.step_compare    = cmp_q;
        r.drive_indicator = ind_q;
        r.center_position = ctr_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Event queue; each entry carries its predicted status
    // ------------------------------------------------------------------
    t_pending pending_events [$];
    t_result  expected_status [$];
    int items_queued = 0;
    int items_taken  = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int done_seen    = 0;
    int loads_seen   = 0;
    int cfg_settings = 1;
    int hold_requests = 0;

    function automatic t_item rand_event(input logic [2:0] op);
        t_item ev;
        ev.op           = op;
        ev.limit_active = 1'($urandom_range(0, 1));
        ev.table_index  = 10'($urandom_range(0, 1023));
        ev.table_period = 17'($urandom_range(0, 131071));
        ev.new_mode     = 3'($urandom_range(0, 7));
        ev.run_request  = 1'($urandom_range(0, 1));
        return ev;
    endfunction

    // Predicts and queues one event. A tick in profile mode that would read an
    // entry never loaded gets a load of that entry placed in front of it.
    task automatic post_event(input t_item ev);
        t_pending p;
        t_item    fill;
        logic [9:0] slot;
        if (ev.op == OP_TICK && mode_q == MODE_PROFILE) begin
            slot = (pidx_q > plast_cfg) ? 10'd0 : pidx_q;
            if (!written_q[slot]) begin
                fill = rand_event(OP_LOAD);
                fill.table_index = slot;
                post_event(fill);
            end
        end
        p.ev     = ev;
        p.status = axis_step(ev);
        pending_events.push_back(p);
        items_queued++;
    endtask

    task automatic post_op(input logic [2:0] op);
        post_event(rand_event(op));
    endtask

    task automatic post_limit(input logic [2:0] op, input logic pressed);
        t_item ev;
        ev = rand_event(op);
        ev.limit_active = pressed;
        post_event(ev);
    endtask

    task automatic post_mode(input logic [2:0] m, input logic run);
        t_item ev;
        ev = rand_event(OP_SET_MODE);
        ev.new_mode    = m;
        ev.run_request = run;
        post_event(ev);
    endtask

    task automatic post_load(input logic [9:0] idx, input logic [16:0] per);
        t_item ev;
        ev = rand_event(OP_LOAD);
        ev.table_index  = idx;
        ev.table_period = per;
        post_event(ev);
    endtask

    task automatic post_random_load();
        logic [16:0] per;
        logic [9:0]  idx;
        idx = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                          : 10'($urandom_range(0, plast_cfg));
        if ($urandom_range(0, 2) == 0)
            per = 17'($urandom_range(0, 131071));
        else
            per = 17'($urandom_range(0, 400)) - 17'd200;
        post_load(idx, per);
    endtask

    // Random part: mostly complete calibration and return/playback sequences
    // with random content, the rest loose events and broken sequences.
    task automatic run_random(input int n_items);
        int stop_at;
        int guard;
        int r;
        int steps;
        logic signed [31:0] home_s;
        stop_at = items_queued + n_items;
        while (items_queued < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                // calibration: right limit, walk down, left limit, walk to centre
                if ($urandom_range(0, 1)) post_op(OP_STOP);
                else post_mode(MODE_IDLE, 1'b1);
                if ($urandom_range(0, 3) == 0) post_limit(OP_RIGHT_LIM, 1'b0);
                post_limit(OP_RIGHT_LIM, 1'b1);
                repeat ($urandom_range(0, 40)) begin
                    if ($urandom_range(0, 14) == 0)
                        post_event(rand_event(3'($urandom_range(0, 7))));
                    post_op(OP_STEP);
                end
                if ($urandom_range(0, 3) == 0) post_limit(OP_LEFT_LIM, 1'b0);
                post_limit(OP_LEFT_LIM, 1'b1);
                guard = 0;
                while (mode_q == MODE_CENTERING && guard < 50) begin
                    post_op(OP_STEP);
                    guard++;
                end
            end else if (r < 65) begin
                // steer the axis so that home lies ahead, then return and play
                home_s = $signed(home_cfg);
                steps  = $urandom_range(0, 5);
                if (home_s > -50 && home_s < 0) begin
                    post_op(OP_STOP);
                    post_limit(OP_RIGHT_LIM, 1'b1);
                    steps = 80;
                end else if (home_s >= 0 && home_s < 50) begin
                    post_op(OP_STOP);
                    post_limit(OP_RIGHT_LIM, 1'b1);
                    repeat ($urandom_range(1, 8)) post_op(OP_STEP);
                    post_limit(OP_LEFT_LIM, 1'b1);
                    steps = 80;
                end
                post_mode(MODE_RETURN, 1'b1);
                guard = 0;
                while (mode_q == MODE_RETURN && guard < steps) begin
                    post_op(OP_STEP);
                    guard++;
                end
                if (mode_q != MODE_PROFILE)
                    post_mode(MODE_PROFILE, 1'($urandom_range(0, 1)));
                repeat ($urandom_range(1, 30)) begin
                    case ($urandom_range(0, 9))
                        0: post_random_load();
                        1: post_op(OP_STEP);
                        default: post_op(OP_TICK);
                    endcase
                end
            end else if (r < 75) begin
                repeat ($urandom_range(1, 8)) post_random_load();
            end else begin
                repeat ($urandom_range(1, 6))
                    post_event(rand_event(3'($urandom_range(0, 7))));
            end
        end
    endtask

    // Waits until every queued event has been taken and answered.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (items_taken != items_queued || expected_status.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_HOME_POSITION)
            home_cfg = data;
        else
            plast_cfg = data[9:0];
    endtask

    task automatic run_phase(input logic [31:0] home, input logic [9:0] last,
                             input bit hold, input int n_items);
        wait_drained();
        write_cfg(CFG_HOME_POSITION, home);
        write_cfg(CFG_PROFILE_LAST, 32'(last));
        cfg_settings++;
        if (hold)
            hold_requests++;
        run_random(n_items);
    endtask

    // ------------------------------------------------------------------
    // Event driver: bursts of random length, random gaps in between
    // ------------------------------------------------------------------
    logic    item_acc = 1'b0;
    t_result drv_exp;
    int      burst_left = 0;
    int      gap_left   = 0;

    always @(negedge clk) begin
        t_pending nxt;
        if (!rst_n) begin
            item_ch.valid <= 1'b0;
        end else if (!item_ch.valid || item_acc) begin
            if (gap_left != 0) begin
                gap_left--;
                item_ch.valid <= 1'b0;
            end else if (pending_events.size() != 0) begin
                nxt = pending_events.pop_front();
                item_ch.valid        <= 1'b1;
                item_ch.op           <= nxt.ev.op;
                item_ch.limit_active <= nxt.ev.limit_active;
                item_ch.table_index  <= nxt.ev.table_index;
                item_ch.table_period <= nxt.ev.table_period;
                item_ch.new_mode     <= nxt.ev.new_mode;
                item_ch.run_request  <= nxt.ev.run_request;
                drv_exp              <= nxt.status;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Status receiver: stall pattern of its own plus requested long holds
    // ------------------------------------------------------------------
    int hold_left     = 0;
    int holds_started = 0;
    int stall_left    = 0;
    int stall_style   = 0;

    always @(negedge clk) begin
        if (hold_left != 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else if (holds_started != hold_requests) begin
            holds_started++;
            hold_left = LONG_HOLD - 1;
            res_ch.ready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_style = $urandom_range(0, 3);
                stall_left  = $urandom_range(16, 160);
            end else begin
                stall_left--;
            end
            case (stall_style)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= 1'($urandom_range(0, 1));
                2: res_ch.ready <= ($urandom_range(0, 4) != 0);
                default: res_ch.ready <= ((stall_left % 5) < 2);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: records event transfers, checks status transfers, watchdog
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("status %0d: %s expected %0h got %0h", results_seen, name, want, got);
        end
    endtask

    always @(posedge clk) begin
        t_result got;
        t_result want;
        bit      moved;
        if (!rst_n) begin
            item_acc    <= 1'b0;
            idle_cycles = 0;
        end else begin
            moved = 1'b0;
            item_acc <= item_ch.valid && item_ch.ready;
            if (item_ch.valid && item_ch.ready) begin
                expected_status.push_back(drv_exp);
                items_taken++;
                moved = 1'b1;
            end
            if (res_ch.valid && res_ch.ready) begin
                moved = 1'b1;
                got.mode            = res_ch.mode;
                got.position        = res_ch.position;
                got.direction       = res_ch.direction;
                got.step_run        = res_ch.step_run;
                got.step_period     = res_ch.step_period;
                got.step_compare    = res_ch.step_compare;
                got.period_load     = res_ch.period_load;
                got.drive_indicator = res_ch.drive_indicator;
                got.home_done       = res_ch.home_done;
                got.center_position = res_ch.center_position;
                if (expected_status.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("status transfer %0d arrived with nothing expected",
                                 results_seen);
                end else begin
                    want = expected_status.pop_front();
                    check_field("mode", 32'(want.mode), 32'(got.mode));
                    check_field("position", want.position, got.position);
                    check_field("direction", 32'(want.direction), 32'(got.direction));
                    check_field("step_run", 32'(want.step_run), 32'(got.step_run));
                    check_field("step_period", 32'(want.step_period),
                                32'(got.step_period));
                    check_field("step_compare", 32'(want.step_compare),
                                32'(got.step_compare));
                    check_field("period_load", 32'(want.period_load),
                                32'(got.period_load));
                    check_field("drive_indicator", 32'(want.drive_indicator),
                                32'(got.drive_indicator));
                    check_field("home_done", 32'(want.home_done), 32'(got.home_done));
                    check_field("center_position", want.center_position,
                                got.center_position);
                end
                if (got.home_done === 1'b1) done_seen++;
                if (got.period_load === 1'b1) loads_seen++;
                results_seen++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("no transfer for %0d cycles, %0d status transfers outstanding",
                         STALL_LIMIT, expected_status.size());
                $display("** stepper_axis_homing_sequencer: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        item_ch.valid        = 1'b0;
        item_ch.op           = OP_STEP;
        item_ch.limit_active = 1'b0;
        item_ch.table_index  = '0;
        item_ch.table_period = '0;
        item_ch.new_mode     = MODE_IDLE;
        item_ch.run_request  = 1'b0;
        res_ch.ready         = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: calibration from reset with an even negative span, return to
        // the reset home, playback of the extreme table entries, aborts.
        post_op(OP_STEP);                       // counts down from zero
        post_op(OP_TICK);                       // no effect outside profile mode
        post_limit(OP_RIGHT_LIM, 1'b0);         // released switch: no change
        post_limit(OP_RIGHT_LIM, 1'b1);
        post_op(OP_STEP);
        post_op(OP_STEP);
        post_limit(OP_LEFT_LIM, 1'b0);
        post_limit(OP_LEFT_LIM, 1'b1);          // centre of -2 is -1
        post_op(OP_STEP);                       // reaches centre
        post_mode(MODE_RETURN, 1'b1);
        post_op(OP_STEP);                       // reaches home at zero
        post_load(10'd0, 17'h10000);            // most negative entry saturates
        post_load(10'd1, 17'd0);                // zero counts as up
        post_load(10'd2, 17'd65535);
        post_load(10'd1023, 17'h1FFFF);
        repeat (3) post_op(OP_TICK);
        post_limit(OP_RIGHT_LIM, 1'b1);         // aborts outside modes 0 and 1
        post_op(OP_STOP);
        post_mode(MODE_UNUSED, 1'b0);
        post_limit(OP_LEFT_LIM, 1'b1);          // mode 7 ignores the left limit
        post_op(OP_UNUSED);
        post_mode(MODE_SPARE, 1'b1);
        post_limit(OP_LEFT_LIM, 1'b1);          // aborts from mode 6

        run_random(200);
        run_phase(32'd5, 10'd3, 1'b0, 220);
        run_phase(-32'sd7, 10'd0, 1'b1, 220);
        run_phase(32'h8000_0000, 10'd1023, 1'b0, 220);
        run_phase(32'h7FFF_FFFF, 10'd15, 1'b1, 220);
        run_phase(-32'sd30, 10'd7, 1'b0, 220);
        run_phase(32'd17, 10'd999, 1'b0, 220);
        run_phase(32'd0, 10'd1, 1'b0, 220);

        wait_drained();
        repeat (20) @(posedge clk);

        $display("%0d events sent under %0d register settings, %0d status transfers checked",
                 items_taken, cfg_settings, results_seen);
        $display("%0d homing completions, %0d profile period loads, %0d field mismatches",
                 done_seen, loads_seen, mismatches);
        if (mismatches == 0 && expected_status.size() == 0)
            $display("** stepper_axis_homing_sequencer: PASSED **");
        else
            $display("** stepper_axis_homing_sequencer: FAILED **");
        $finish;
    end

endmodule
